// File: rtl/pzg_pkg.sv
`default_nettype none

package pzg_pkg;

   localparam int ANGLE_W  = 16;
   localparam int TOOL_W   = 16;
   localparam int FLAT_W   = 8;
   localparam int HOLD_W   = 10;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 10;

   localparam int REQ_DW   = 80;
   localparam int RSP_DW   = 72;

   // number of points shifted in before the window can be judged
   localparam int FILL_W = 3;
   localparam logic [FILL_W-1:0] FILL_DONE = FILL_W'(4);

   localparam logic [HOLD_W-1:0] HOLD_TOL_RESET = HOLD_W'(10);

   localparam logic [TOOL_W-1:0] TOOL_PUMP_MIN    = TOOL_W'(16'h0001);
   localparam logic [TOOL_W-1:0] TOOL_GRIPPER_MIN = TOOL_W'(16'h0010);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = QUEUE_AW + 1;
   localparam logic [QUEUE_CW-1:0] QUEUE_FULL = QUEUE_CW'(QUEUE_DEPTH);

   typedef enum logic [CSR_AW-1:0] {
      CSR_FLAT_TOL = 2'd0,
      CSR_HOLD_TOL = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      TOOL_RELEASE = 2'd0,
      TOOL_PUMP    = 2'd1,
      TOOL_GRIPPER = 2'd2
   } tool_action_type;

   // x in the lowest bits
   typedef struct packed {
      logic [TOOL_W-1:0]  tool;
      logic [ANGLE_W-1:0] wrist;
      logic [ANGLE_W-1:0] z;
      logic [ANGLE_W-1:0] y;
      logic [ANGLE_W-1:0] x;
   } point_type;

   typedef struct packed {
      logic      hold;
      point_type pt;
   } q_entry_type;

   typedef struct packed {
      logic               hold;
      tool_action_type    action;
      logic [ANGLE_W-1:0] wrist;
      logic [ANGLE_W-1:0] z;
      logic [ANGLE_W-1:0] y;
      logic [ANGLE_W-1:0] x;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/playback_zigzag_glitch_filter.sv
`default_nettype none

// Zigzag glitch filter for recorded arm playback. Points enter on req_ (one per
// cycle while req_tready is high, no bubbles needed) and pass through a five-point
// window; the first four points only fill it. Each later point yields either
// nothing (the centre point zigzags on x, y or z beyond flat_tolerance and is
// dropped) or the centre point with a hold flag and a decoded tool action on rsp_.
// The window judges a taken point combinationally and pushes its result into a
// four-entry queue; from there it goes to the output register, and req_tready
// falls only when that queue is full. csr_addr 0 writes flat_tolerance
// (reset 0), csr_addr 1 writes hold_tolerance (reset 10); write only while idle.
module playback_zigzag_glitch_filter
   import pzg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // point_x, point_y, point_z, point_wrist, tool_code
   input  wire logic [REQ_DW-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // out_x, out_y, out_z, out_wrist, tool_action, hold_point, zero pad
   output logic [RSP_DW-1:0]      rsp_tdata,
   input  wire logic              csr_we,
   input  wire logic [CSR_AW-1:0] csr_addr,
   input  wire logic [CSR_DW-1:0] csr_wdata
);

   logic [FLAT_W-1:0] flat_tol_ff;
   logic [HOLD_W-1:0] hold_tol_ff;
   point_type   req_point;
   q_entry_type push_entry, pop_entry;
   logic        push_valid, push_ready, pop_valid, pop_ready;
   result_type  rsp_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         flat_tol_ff <= '0;
         hold_tol_ff <= HOLD_TOL_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FLAT_TOL: flat_tol_ff <= csr_wdata[FLAT_W-1:0];
            CSR_HOLD_TOL: hold_tol_ff <= csr_wdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_point = req_tdata;

   pzg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .flat_tol   (flat_tol_ff),
      .hold_tol   (hold_tol_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_point  (req_point),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   pzg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   pzg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {{(RSP_DW - $bits(result_type)){1'b0}}, rsp_result};

endmodule

`default_nettype wire

// File: rtl/pzg_front.sv
`default_nettype none

module pzg_front
   import pzg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [FLAT_W-1:0] flat_tol,
   input  wire logic [HOLD_W-1:0] hold_tol,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire point_type         req_point,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output q_entry_type            push_entry
);

   point_type p2_ff, p1_ff, c_ff, n1_ff, n2_ff;
   point_type p2_in, p1_in, c_in, n1_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic kept_ff, kept_in;
   logic accept, fill_done, shift_all;
   logic zz_x, zz_y, zz_z, zigzag, hold;

   // {moving, downward}
   function automatic logic [1:0] step_dir(input logic [ANGLE_W-1:0] from,
                                           input logic [ANGLE_W-1:0] to,
                                           input logic [FLAT_W-1:0]  tol);
      logic [ANGLE_W:0]   diff;
      logic [ANGLE_W-1:0] mag;
      begin
         diff = {1'b0, to} - {1'b0, from};
         mag  = diff[ANGLE_W] ? (from - to) : diff[ANGLE_W-1:0];
         step_dir = {mag > {{(ANGLE_W-FLAT_W){1'b0}}, tol}, diff[ANGLE_W]};
      end
   endfunction

   function automatic logic zig(input logic [ANGLE_W-1:0] a,
                                input logic [ANGLE_W-1:0] b,
                                input logic [ANGLE_W-1:0] c,
                                input logic [ANGLE_W-1:0] d,
                                input logic [FLAT_W-1:0]  tol);
      logic [1:0] d0, d1, d2;
      begin
         d0  = step_dir(a, b, tol);
         d1  = step_dir(b, c, tol);
         d2  = step_dir(c, d, tol);
         zig = d0[1] && d1[1] && d2[1] && (d1[0] != d0[0]) && (d1[0] != d2[0]);
      end
   endfunction

   function automatic logic near(input logic [ANGLE_W-1:0] a,
                                 input logic [ANGLE_W-1:0] b,
                                 input logic [HOLD_W-1:0]  tol);
      logic [ANGLE_W-1:0] mag;
      begin
         mag  = (a > b) ? (a - b) : (b - a);
         near = mag <= {{(ANGLE_W-HOLD_W){1'b0}}, tol};
      end
   endfunction

   assign fill_done = (fill_ff == FILL_DONE);
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   // a rejected centre is dropped: older two stay, later ones move down
   assign shift_all = !fill_done || kept_ff;

   always_comb begin
      p2_in = shift_all ? p1_ff : p2_ff;
      p1_in = shift_all ? c_ff  : p1_ff;
      c_in  = n1_ff;
      n1_in = n2_ff;
   end

   always_comb begin
      zz_x   = zig(p2_in.x, p1_in.x, c_in.x, n1_in.x, flat_tol);
      zz_y   = zig(p2_in.y, p1_in.y, c_in.y, n1_in.y, flat_tol);
      zz_z   = zig(p2_in.z, p1_in.z, c_in.z, n1_in.z, flat_tol);
      zigzag = zz_x || zz_y || zz_z;
      hold   = near(c_in.x, p1_in.x, hold_tol) && near(c_in.y, p1_in.y, hold_tol) &&
               near(c_in.z, p1_in.z, hold_tol);
   end

   always_comb begin
      fill_in = fill_ff;
      kept_in = kept_ff;
      if (accept) begin
         if (!fill_done) begin
            fill_in = fill_ff + FILL_W'(1);
         end else begin
            kept_in = !zigzag;
         end
      end
   end

   assign push_valid      = accept && fill_done && !zigzag;
   assign push_entry.hold = hold;
   assign push_entry.pt   = c_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         kept_ff <= 1'b1;
      end else begin
         fill_ff <= fill_in;
         kept_ff <= kept_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p2_ff <= p2_in;
         p1_ff <= p1_in;
         c_ff  <= c_in;
         n1_ff <= n1_in;
         n2_ff <= req_point;
      end
   end

endmodule

`default_nettype wire

// File: rtl/pzg_queue.sv
`default_nettype none

module pzg_queue
   import pzg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push_valid,
   output logic             push_ready,
   input  wire q_entry_type push_entry,
   output logic             pop_valid,
   input  wire logic        pop_ready,
   output q_entry_type      pop_entry
);

   q_entry_type mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + QUEUE_CW'(1);
         2'b01:   count_in = count_ff - QUEUE_CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: rtl/pzg_back.sv
`default_nettype none

module pzg_back
   import pzg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        pop_valid,
   output logic             pop_ready,
   input  wire q_entry_type pop_entry,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output result_type       rsp_result
);

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   assign pop_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in.x     = pop_entry.pt.x;
      rsp_in.y     = pop_entry.pt.y;
      rsp_in.z     = pop_entry.pt.z;
      rsp_in.wrist = pop_entry.pt.wrist;
      rsp_in.hold  = pop_entry.hold;
      if (pop_entry.pt.tool >= TOOL_GRIPPER_MIN) begin
         rsp_in.action = TOOL_GRIPPER;
      end else if (pop_entry.pt.tool >= TOOL_PUMP_MIN) begin
         rsp_in.action = TOOL_PUMP;
      end else begin
         rsp_in.action = TOOL_RELEASE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop_ready) begin
         rsp_valid_in = pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/pzg_checker.sv
`default_nettype none

module pzg_checker
   import pzg_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [RSP_DW-1:0] rsp_tdata
);

   // points taken since reset, saturating once the window is full
   logic [FILL_W-1:0] seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (req_tvalid && req_tready && seen_ff <= FILL_DONE) begin
         seen_ff <= seen_ff + FILL_W'(1);
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   a_fill_first: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> seen_ff > FILL_DONE)
      else $error("result before five points were taken");

   a_action_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[65:64] != 2'b11)
      else $error("undefined tool action");

endmodule

bind playback_zigzag_glitch_filter pzg_checker u_pzg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: tb/tb_playback_zigzag_glitch_filter.sv
`default_nettype none

module tb_playback_zigzag_glitch_filter;
   import pzg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN_DEPTH     = 5;
   localparam int ITEMS_PER_SET = 200;
   localparam int NUM_SETS      = 6;
   localparam int DRAIN_CYCLES  = 8;
   // indexes the block has no register behind
   localparam logic [CSR_AW-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_SPARE_HI = 2'd3;

   typedef enum int {
      ROW_PREDICT,
      ROW_NONE,
      ROW_RESULT
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      point_type    pt;
      result_type   res;
   } directed_row_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   // point_x, point_y, point_z, point_wrist, tool_code
   logic [REQ_DW-1:0] req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   // out_x, out_y, out_z, out_wrist, tool_action, hold_point, zero pad
   logic [RSP_DW-1:0] rsp_tdata;
   logic              csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   playback_zigzag_glitch_filter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // filter state as the block should hold it
   point_type         win [WIN_DEPTH];
   int                win_base;
   int                fill_cnt;
   bit                centre_kept;
   logic [FLAT_W-1:0] flat_tol;
   logic [HOLD_W-1:0] hold_tol;

   result_type kept_centres[$];
   int         mismatches = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;

   directed_row_type directed_rows [20] = '{
      // filling: nothing comes out
      '{ROW_NONE,   {16'd0,     16'd0, 16'd0, 16'd0, 16'd0}, '0},
      '{ROW_NONE,   {16'd1,     16'd0, 16'd0, 16'd0, 16'd0}, '0},
      '{ROW_NONE,   {16'd15,    16'd0, 16'd0, 16'd0, 16'd0}, '0},
      '{ROW_NONE,   {16'd16,    16'd0, 16'd0, 16'd0, 16'd0}, '0},
      // still window: centres pass as holds until the jump to FFFF, tool decoded at its bounds
      '{ROW_RESULT, {16'hFFFF,  16'd0, 16'd0, 16'd0, 16'd0},
                    {1'b1, TOOL_PUMP, 64'd0}},
      '{ROW_RESULT, {16'd0,     {4{16'hFFFF}}},
                    {1'b1, TOOL_GRIPPER, 64'd0}},
      '{ROW_RESULT, {16'd0,     16'd0, 16'd0, 16'd0, 16'd0},
                    {1'b1, TOOL_GRIPPER, 64'd0}},
      '{ROW_RESULT, {16'd0,     16'd0, 16'd0, 16'd0, 16'd0},
                    {1'b0, TOOL_RELEASE, {4{16'hFFFF}}}},
      // x zigzag: centres dropped, window shifts down
      '{ROW_PREDICT, {16'd3,    16'd0, 16'd0, 16'd0, 16'd1000}, '0},
      '{ROW_PREDICT, {16'd3,    16'd0, 16'd0, 16'd0, 16'd2000}, '0},
      '{ROW_PREDICT, {16'd3,    16'd0, 16'd0, 16'd0, 16'd1000}, '0},
      '{ROW_PREDICT, {16'd3,    16'd0, 16'd0, 16'd0, 16'd2000}, '0},
      '{ROW_PREDICT, {16'd3,    16'd0, 16'd0, 16'd0, 16'd1000}, '0},
      // hold tolerance edge: exactly on it, then one past
      '{ROW_PREDICT, {16'd20,   16'd0, 16'd0, 16'd0, 16'd1010}, '0},
      '{ROW_PREDICT, {16'd20,   16'd0, 16'd0, 16'd0, 16'd1021}, '0},
      '{ROW_PREDICT, {16'd0,    16'd0, 16'd0, 16'd1, 16'd1021}, '0},
      // wrist swings are not judged
      '{ROW_PREDICT, {16'd0,    16'd0,     16'd0, 16'd1, 16'd1021}, '0},
      '{ROW_PREDICT, {16'd0,    16'hFFFF,  16'd0, 16'd1, 16'd1021}, '0},
      '{ROW_PREDICT, {16'd0,    16'd0,     16'd0, 16'd1, 16'd1021}, '0},
      '{ROW_PREDICT, {16'd9,    16'hFFFF,  16'd0, 16'd1, 16'd1021}, '0}
   };

   function automatic int slot(input int offset);
      return (win_base + offset) % WIN_DEPTH;
   endfunction

   function automatic logic [ANGLE_W-1:0] axis_of(input point_type p, input int a);
      case (a)
         0: return p.x;
         1: return p.y;
         default: return p.z;
      endcase
   endfunction

   function automatic logic [ANGLE_W-1:0] abs_delta(input logic [ANGLE_W-1:0] a,
                                                    input logic [ANGLE_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic int step_dir(input logic [ANGLE_W-1:0] from,
                                   input logic [ANGLE_W-1:0] to);
      if (abs_delta(to, from) <= flat_tol) return 0;
      return (to > from) ? 1 : -1;
   endfunction

   task automatic filter_point(input point_type p, output bit emitted,
                               output result_type r);
      int d0, d1, d2;
      bit ok, hold;
      point_type c, pre;
      emitted = 1'b0;
      r = '0;
      if (fill_cnt < FILL_DONE) begin
         win[(win_base + fill_cnt + 1) % WIN_DEPTH] = p;
         fill_cnt++;
         return;
      end
      if (centre_kept) begin
         win_base = (win_base + 1) % WIN_DEPTH;
      end else begin
         win[slot(2)] = win[slot(3)];
         win[slot(3)] = win[slot(4)];
      end
      win[slot(4)] = p;
      ok = 1'b1;
      for (int a = 0; a < 3; a++) begin
         d0 = step_dir(axis_of(win[slot(0)], a), axis_of(win[slot(1)], a));
         d1 = step_dir(axis_of(win[slot(1)], a), axis_of(win[slot(2)], a));
         d2 = step_dir(axis_of(win[slot(2)], a), axis_of(win[slot(3)], a));
         if (d0 != 0 && d1 != 0 && d2 != 0 && d1 != d0 && d1 != d2) ok = 1'b0;
      end
      centre_kept = ok;
      if (!ok) return;
      c = win[slot(2)];
      pre = win[slot(1)];
      hold = 1'b1;
      for (int a = 0; a < 3; a++) begin
         if (abs_delta(axis_of(c, a), axis_of(pre, a)) > hold_tol) hold = 1'b0;
      end
      r.x = c.x;
      r.y = c.y;
      r.z = c.z;
      r.wrist = c.wrist;
      r.hold = hold;
      if (c.tool >= TOOL_GRIPPER_MIN) r.action = TOOL_GRIPPER;
      else if (c.tool >= TOOL_PUMP_MIN) r.action = TOOL_PUMP;
      else r.action = TOOL_RELEASE;
      emitted = 1'b1;
   endtask

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic send_point(input point_type p, input row_kind_type kind,
                             input result_type typed);
      bit emitted;
      result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata = p;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      filter_point(p, emitted, r);
      if (kind == ROW_RESULT) kept_centres.push_back(typed);
      else if (kind == ROW_PREDICT && emitted) kept_centres.push_back(r);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] val);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_FLAT_TOL) flat_tol = val[FLAT_W-1:0];
      else if (idx == CSR_HOLD_TOL) hold_tol = val[HOLD_W-1:0];
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (kept_centres.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // mostly small moves around the tolerances, now and then a point anywhere
   function automatic point_type next_point(input point_type prev, input int span);
      point_type p;
      if ($urandom_range(7) == 0) begin
         p.x = 16'($urandom);
         p.y = 16'($urandom);
         p.z = 16'($urandom);
      end else begin
         p.x = prev.x + 16'($urandom_range(2 * span) - span);
         p.y = prev.y + 16'($urandom_range(2 * span) - span);
         p.z = prev.z + 16'($urandom_range(2 * span) - span);
      end
      p.wrist = 16'($urandom);
      case ($urandom_range(3))
         0: p.tool = '0;
         1: p.tool = 16'($urandom_range(15, 1));
         2: p.tool = 16'($urandom_range(16'hFFFF, 16));
         default: p.tool = 16'($urandom);
      endcase
      return p;
   endfunction

   task automatic check_field(input string name, input logic [ANGLE_W-1:0] want,
                              input logic [ANGLE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   result_type got_res, want_res;

   always @(negedge clock) rsp_tready = ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_res = result_type'(rsp_tdata[$bits(result_type)-1:0]);
         if (kept_centres.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual %p", $time, got_res);
            mismatches++;
         end else begin
            want_res = kept_centres.pop_front();
            check_field("out_x", want_res.x, got_res.x);
            check_field("out_y", want_res.y, got_res.y);
            check_field("out_z", want_res.z, got_res.z);
            check_field("out_wrist", want_res.wrist, got_res.wrist);
            check_field("tool_action", 16'(want_res.action), 16'(got_res.action));
            check_field("hold_point", 16'(want_res.hold), 16'(got_res.hold));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int flat_set [NUM_SETS] = '{255, 0, 3, -1, 40, 768};
      int hold_set [NUM_SETS] = '{1023, 0, 10, -1, 200, -1};
      point_type last_pt;
      int span;

      foreach (win[i]) win[i] = '0;
      win_base = 0;
      fill_cnt = 0;
      centre_kept = 1'b1;
      flat_tol = '0;
      hold_tol = HOLD_TOL_RESET;
      last_pt = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 29;
      recv_idle_pct = 76;
      foreach (directed_rows[i]) begin
         send_point(directed_rows[i].pt, directed_rows[i].kind, directed_rows[i].res);
         last_pt = directed_rows[i].pt;
      end

      for (int s = 0; s < NUM_SETS; s++) begin
         wait_drained();
         // 768 into the 8-bit flat register keeps only zero
         write_reg(CSR_FLAT_TOL, (flat_set[s] < 0) ? CSR_DW'($urandom_range(255))
                                                   : CSR_DW'(flat_set[s]));
         write_reg(CSR_HOLD_TOL, (hold_set[s] < 0) ? CSR_DW'($urandom_range(1023))
                                                   : CSR_DW'(hold_set[s]));
         write_reg((s % 2 == 0) ? CSR_SPARE_LO : CSR_SPARE_HI, CSR_DW'($urandom));
         if (s < 2) begin
            send_idle_pct = 29;
            recv_idle_pct = 76;
         end else if (s < 4) begin
            send_idle_pct = 76;
            recv_idle_pct = 29;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         span = 2 * flat_tol + 24;
         for (int n = 0; n < ITEMS_PER_SET; n++) begin
            if (s == 1 && n == ITEMS_PER_SET / 2) begin
               req_tvalid = 1'b0;
               while (kept_centres.size() != 0) @(negedge clock);
            end
            last_pt = next_point(last_pt, span);
            send_point(last_pt, ROW_PREDICT, '0);
         end
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
